[src/orqs_pkg.sv]
// Package: types, constants and codes for the ordered request queue.
`default_nettype none
package orqs_pkg;
	localparam int Capacity = 64;
	localparam int PosW = $clog2(Capacity);
	localparam int CntW = $clog2(Capacity + 1);
	localparam int EntW = 15 + 32 + 20;

	typedef enum logic [3:0] {
		M_INSERT = 4'd0, M_DEQUEUE = 4'd1, M_CONTAINS = 4'd2, M_READ_IDX = 4'd3,
		M_TIME_KEY = 4'd4, M_REM_IDX = 4'd5, M_REM_KEY = 4'd6, M_ITER_FIRST = 4'd7,
		M_ITER_NEXT = 4'd8
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_BADARG = 3'd1, ST_PRESENT = 3'd2, ST_FULL = 3'd3,
		ST_NOTFOUND = 3'd4, ST_EMPTY = 3'd5, ST_FINISHED = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_SEARCH, S_FETCH, S_SHIFT, S_DONE
	} state_t;

	typedef struct packed {
		logic [3:0]  mode;
		logic signed [15:0] key;
		logic [31:0] arrival_sec;
		logic [19:0] arrival_usec;
		logic [6:0]  index;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        found;
		logic [14:0] key_out;
		logic [31:0] time_sec_out;
		logic [19:0] time_usec_out;
		logic [6:0]  occupancy;
	} rsp_t;
endpackage
`default_nettype wire

[src/orqs_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module orqs_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[src/ordered_request_queue_with_search_unit.sv]
// Top level: request queue with associative search and gap-closing removal.
`default_nettype none
// Channel | dir | payload | handshake
// req     | in  | req_t   | req_valid / req_stall
// rsp     | out | rsp_t   | rsp_valid / rsp_stall
//
// One request at a time. Entries live in one RAM (key, sec, usec packed),
// with registered read data. Key search and tail shift are pipelined, one
// entry per cycle. A key search stops at the first matching entry; removing
// position p moves every entry above p down by one place.
// Reset clears the count, cursor and sequencer; the RAM needs no clearing,
// as only entries below the count are read.
// The result sits in an output register until taken; req_stall is high
// from acceptance until the result has been taken. A stall on rsp delays
// the next acceptance.
module ordered_request_queue_with_search_unit
	import orqs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);
	state_t state_q, state_d;
	req_t   req_q;
	logic [CntW-1:0] count_q, count_d;
	logic [PosW-1:0] cur_q, cur_d;
	logic            cur_v_q, cur_v_d;
	logic [CntW-1:0] ptr_q, ptr_d;        // next read position
	logic            rd_pend_q, rd_pend_d; // a read was issued last cycle
	logic [PosW-1:0] hit_q, hit_d;        // position being reported or removed
	rsp_t            rsp_q, rsp_d;

	// RAM
	logic            we;
	logic [PosW-1:0] waddr, raddr;
	logic [EntW-1:0] wdata, rdata;

	orqs_ram #(.Width(EntW), .Depth(Capacity)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic        neg;
	logic [14:0] k;
	logic [14:0] rd_key;
	logic        accept;
	logic        idx_bad;
	logic        search_mode;
	logic        is_removal;
	logic        key_hit;
	logic        walk;
	logic [CntW-1:0] cur_next;
	logic        iter_more;
	logic        go_fetch;
	logic        shift_rd;

	assign neg    = req_q.key[15];
	assign k      = req_q.key[14:0];
	assign rd_key = rdata[EntW-1 -: 15];
	assign accept = req_valid && !req_stall;
	assign idx_bad = (req_q.index == 7'd0) ||
		(CntW'(req_q.index) > count_q) || (req_q.index > 7'(Capacity));

	assign search_mode = req_q.mode inside {M_INSERT, M_CONTAINS, M_TIME_KEY, M_REM_KEY};
	assign is_removal  = req_q.mode inside {M_DEQUEUE, M_REM_IDX, M_REM_KEY};
	// returned entry (read at ptr-1) matches the key
	assign key_hit   = rd_pend_q && (rd_key == k);
	// more entries left to read in the key walk
	assign walk      = search_mode && !neg && (ptr_q < count_q);
	assign cur_next  = CntW'(cur_q) + CntW'(1);
	assign iter_more = cur_v_q && (cur_next < count_q);
	// requests that report one entry found without a key search
	assign go_fetch  = ((req_q.mode == M_DEQUEUE || req_q.mode == M_ITER_FIRST) &&
		count_q != '0) ||
		((req_q.mode == M_READ_IDX || req_q.mode == M_REM_IDX) && !idx_bad) ||
		(req_q.mode == M_ITER_NEXT && iter_more);
	// shift still has an entry to read (count_q already holds the new count)
	assign shift_rd  = (ptr_q <= count_q);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = (state_q == S_DONE);
	assign rsp       = rsp_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (req_valid) state_d = S_SEARCH;
			S_SEARCH: begin
				if (key_hit) state_d = S_FETCH;
				else if (!walk) state_d = go_fetch ? S_FETCH : S_DONE;
			end
			S_FETCH:  if (rd_pend_q) state_d = is_removal ? S_SHIFT : S_DONE;
			S_SHIFT:  if (!shift_rd) state_d = S_DONE;
			S_DONE:   if (!rsp_stall) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// RAM access, queue state and result
	always_comb begin
		raddr     = ptr_q[PosW-1:0];
		we        = 1'b0;
		waddr     = PosW'(ptr_q - CntW'(2));
		wdata     = rdata;
		ptr_d     = ptr_q;
		rd_pend_d = 1'b0;
		hit_d     = hit_q;
		count_d   = count_q;
		cur_d     = cur_q;
		cur_v_d   = cur_v_q;
		rsp_d     = rsp_q;
		unique case (state_q)
			S_IDLE: ptr_d = '0;
			S_SEARCH: begin
				if (key_hit) begin
					hit_d = PosW'(ptr_q - CntW'(1));
					ptr_d = ptr_q - CntW'(1);
				end else if (walk) begin
					ptr_d     = ptr_q + CntW'(1);
					rd_pend_d = 1'b1;
				end else begin
					// search over (or not a search): decide the request
					rsp_d = '0;
					rsp_d.occupancy = count_q;
					case (req_q.mode) inside
						M_INSERT: begin
							cur_v_d = 1'b0;
							cur_d   = '0;
							if (neg) rsp_d.status = ST_BADARG;
							else if (count_q >= CntW'(Capacity)) rsp_d.status = ST_FULL;
							else begin
								we    = 1'b1;
								waddr = count_q[PosW-1:0];
								wdata = {k, req_q.arrival_sec, req_q.arrival_usec};
								count_d = count_q + CntW'(1);
								rsp_d.occupancy = count_q + CntW'(1);
							end
						end
						M_CONTAINS, M_REM_KEY:
							rsp_d.status = neg ? ST_BADARG : ST_NOTFOUND;
						M_TIME_KEY:
							rsp_d.status = neg ? ST_BADARG :
								(count_q == '0) ? ST_EMPTY : ST_NOTFOUND;
						M_DEQUEUE, M_ITER_FIRST: begin
							if (count_q == '0) rsp_d.status = ST_EMPTY;
							else begin
								hit_d = '0;
								ptr_d = '0;
							end
						end
						M_READ_IDX, M_REM_IDX: begin
							if (idx_bad) rsp_d.status = ST_BADARG;
							else begin
								hit_d = PosW'(req_q.index - 7'd1);
								ptr_d = CntW'(req_q.index - 7'd1);
							end
						end
						M_ITER_NEXT: begin
							if (count_q == '0) rsp_d.status = ST_EMPTY;
							else if (!cur_v_q) rsp_d.status = ST_BADARG;
							else if (!iter_more) begin
								rsp_d.status = ST_FINISHED;
								cur_v_d = 1'b0;
								cur_d   = '0;
							end else begin
								hit_d = cur_q + PosW'(1);
								ptr_d = cur_next;
							end
						end
						default: rsp_d.status = ST_BADARG;
					endcase
				end
			end
			S_FETCH: begin
				// read the hit entry, then report and maybe remove it
				if (!rd_pend_q) rd_pend_d = 1'b1;
				else begin
					rsp_d = '0;
					rsp_d.occupancy     = count_q;
					rsp_d.key_out       = rd_key;
					rsp_d.time_sec_out  = rdata[51:20];
					rsp_d.time_usec_out = rdata[19:0];
					case (req_q.mode) inside
						M_CONTAINS: begin
							rsp_d.found = 1'b1;
							rsp_d.key_out = '0;
							rsp_d.time_sec_out = '0;
							rsp_d.time_usec_out = '0;
						end
						M_INSERT: begin
							rsp_d.status = ST_PRESENT;
							rsp_d.key_out = '0;
							rsp_d.time_sec_out = '0;
							rsp_d.time_usec_out = '0;
							cur_v_d = 1'b0;
							cur_d   = '0;
						end
						M_ITER_FIRST: begin
							cur_v_d = 1'b1;
							cur_d   = '0;
						end
						M_ITER_NEXT: cur_d = hit_q;
						M_DEQUEUE, M_REM_IDX, M_REM_KEY: begin
							count_d = count_q - CntW'(1);
							rsp_d.occupancy = count_q - CntW'(1);
							ptr_d = CntW'(hit_q) + CntW'(1);
							// cursor keeps its entry; on the removed one it goes
							if (cur_v_q) begin
								if (cur_q == hit_q) begin
									cur_v_d = 1'b0;
									cur_d   = '0;
								end else if (cur_q > hit_q) cur_d = cur_q - PosW'(1);
							end
						end
						default: ;
					endcase
				end
			end
			S_SHIFT: begin
				// read entry ptr; the entry read last cycle goes down to ptr-2
				if (rd_pend_q) we = 1'b1;
				if (shift_rd) begin
					ptr_d     = ptr_q + CntW'(1);
					rd_pend_d = 1'b1;
				end
			end
			S_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			req_q     <= '0;
			count_q   <= '0;
			cur_q     <= '0;
			cur_v_q   <= 1'b0;
			ptr_q     <= '0;
			rd_pend_q <= 1'b0;
			hit_q     <= '0;
			rsp_q     <= '0;
		end else begin
			state_q   <= state_d;
			if (accept) req_q <= req;
			count_q   <= count_d;
			cur_q     <= cur_d;
			cur_v_q   <= cur_v_d;
			ptr_q     <= ptr_d;
			rd_pend_q <= rd_pend_d;
			hit_q     <= hit_d;
			rsp_q     <= rsp_d;
		end
	end
endmodule
`default_nettype wire
